/* rtl/core/simd8_pkg.sv */
package simd8_pkg;

    localparam int PHYS_LANES = 8;
    localparam int LANE_W     = 32;
    localparam int PAIR_W     = 2 * LANE_W;
    localparam int SHAMT_W    = 5;
    localparam int MULH_SHIFT = 16;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_MULH = 4'd3,
        OP_MAX  = 4'd4,
        OP_MIN  = 4'd5,
        OP_SRL  = 4'd6,
        OP_SLL  = 4'd7,
        OP_SRA  = 4'd8
    } op_e;

    typedef enum logic {
        CMD_ELEM   = 1'b0,
        CMD_REDUCE = 1'b1
    } cmd_e;

    typedef struct packed {
        logic              cmd;
        logic [3:0]        op;
        logic              is_signed;
        logic              last_row;
        logic [PAIR_W-1:0] a_pair0;
        logic [PAIR_W-1:0] a_pair1;
        logic [PAIR_W-1:0] a_pair2;
        logic [PAIR_W-1:0] a_pair3;
        logic [PAIR_W-1:0] b_pair0;
        logic [PAIR_W-1:0] b_pair1;
        logic [PAIR_W-1:0] b_pair2;
        logic [PAIR_W-1:0] b_pair3;
    } req_t;

    typedef struct packed {
        logic              from_reduce;
        logic [PAIR_W-1:0] r_pair0;
        logic [PAIR_W-1:0] r_pair1;
        logic [PAIR_W-1:0] r_pair2;
        logic [PAIR_W-1:0] r_pair3;
    } rsp_t;

    // Control broadcast from the top level to every lane
    typedef struct packed {
        logic       accept;
        logic       cmd;
        logic [3:0] op;
        logic       is_signed;
        logic       running;
    } lane_ctl_t;

endpackage

/* rtl/core/simd8_lane.sv */
module simd8_lane
    import simd8_pkg::*;
(
    input  logic              clk,
    input  lane_ctl_t         ctl,
    input  logic [LANE_W-1:0] x,
    input  logic [LANE_W-1:0] b,
    output logic [LANE_W-1:0] res
);

    logic [LANE_W-1:0]  acc_reg;
    logic [LANE_W-1:0]  acc_next;
    logic [LANE_W-1:0]  y;
    logic [LANE_W-1:0]  op_res;
    logic [LANE_W-1:0]  prod;
    logic [LANE_W-1:0]  xs;
    logic [LANE_W-1:0]  ys;
    logic [SHAMT_W-1:0] sh;

    // In reduce mode the accumulator takes the place of B
    assign y    = (ctl.cmd == CMD_REDUCE) ? acc_reg : b;
    assign sh   = x[SHAMT_W-1:0];
    assign prod = x * y;
    // Flip the sign bits so one unsigned compare serves both signednesses
    assign xs   = x ^ {ctl.is_signed, {(LANE_W-1){1'b0}}};
    assign ys   = y ^ {ctl.is_signed, {(LANE_W-1){1'b0}}};

    always_comb
    begin
        case (ctl.op)
            OP_ADD:  op_res = x + y;
            OP_SUB:  op_res = x - y;
            OP_MUL:  op_res = prod;
            OP_MULH: op_res = ctl.is_signed ? $unsigned($signed(prod) >>> MULH_SHIFT)
                                            : (prod >> MULH_SHIFT);
            OP_MAX:  op_res = (xs >= ys) ? x : y;
            OP_MIN:  op_res = (xs <= ys) ? x : y;
            OP_SRL:  op_res = y >> sh;
            OP_SLL:  op_res = y << sh;
            OP_SRA:  op_res = ctl.is_signed ? $unsigned($signed(y) >>> sh) : (y >> sh);
            default: op_res = '0;
        endcase
    end

    // First row of a sequence loads, later rows fold
    assign acc_next = ctl.running ? op_res : x;

    always_ff @(posedge clk)
    begin
        if (ctl.accept && (ctl.cmd == CMD_REDUCE))
        begin
            acc_reg <= acc_next;
        end
    end

    assign res = (ctl.cmd == CMD_REDUCE) ? acc_next : op_res;

endmodule

/* rtl/core/simd8_merge.sv */
module simd8_merge
    import simd8_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              from_reduce,
    input  logic [PHYS_LANES-1:0][LANE_W-1:0] lanes,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output rsp_t                              rsp,
    output logic                              free
);

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    assign free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_next.from_reduce = from_reduce;
        rsp_next.r_pair0     = {lanes[1], lanes[0]};
        rsp_next.r_pair1     = {lanes[3], lanes[2]};
        rsp_next.r_pair2     = {lanes[5], lanes[4]};
        rsp_next.r_pair3     = {lanes[7], lanes[6]};
    end

    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/simd8_int32_elementwise_reduce_alu.sv */
// Eight-lane 32-bit integer SIMD ALU. Each transaction on req carries one row
// of eight A lanes and eight B lanes, an opcode and a signedness flag. With cmd
// clear every lane returns op(A, B) and one transaction leaves on rsp with
// from_reduce clear. With cmd set the row is folded into a per-lane
// accumulator: the first row of a sequence loads it, later rows do
// acc = op(A, acc), B is ignored, and only the row marked last_row produces a
// transaction on rsp, with from_reduce set, carrying the accumulator. Shifts
// take their count from the low five bits of A and shift B (or the
// accumulator); mulh is the low product word shifted right by sixteen. Unsigned
// sra shifts logically and unsigned max/min compare unsigned. Opcodes above sra
// give zero. Throughput is one row per clock unless rsp stalls; a result
// appears on rsp in the cycle after its row is taken. The accept cycle holds
// one 32x32 multiply and the selected operation in every lane, and the
// accumulator loop closes through it, so a reduction folds one row per clock.
// req_ready drops only while a result sits unaccepted in the output register.
// Only the lowest min(LANES, 8) lanes are built; higher result lanes read zero.
module simd8_int32_elementwise_reduce_alu
    import simd8_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic                              accept;
    logic                              emit;
    logic                              free;
    logic                              running_reg;
    logic                              running_next;
    lane_ctl_t                         ctl;
    logic [PHYS_LANES-1:0][PAIR_W/2-1:0] lane_res;
    logic [PHYS_LANES/2-1:0][PAIR_W-1:0] a_pairs;
    logic [PHYS_LANES/2-1:0][PAIR_W-1:0] b_pairs;

    assign req_ready = free;
    assign accept    = req_valid && free;
    // Elementwise rows always answer; reduce rows only on the last one
    assign emit      = (req.cmd == CMD_ELEM) || req.last_row;

    assign a_pairs = {req.a_pair3, req.a_pair2, req.a_pair1, req.a_pair0};
    assign b_pairs = {req.b_pair3, req.b_pair2, req.b_pair1, req.b_pair0};

    always_comb
    begin
        ctl.accept    = accept;
        ctl.cmd       = req.cmd;
        ctl.op        = req.op;
        ctl.is_signed = req.is_signed;
        ctl.running   = running_reg;
    end

    // Open a sequence on any reduce row, close it on the last one
    always_comb
    begin
        running_next = running_reg;
        if (accept && (req.cmd == CMD_REDUCE))
        begin
            running_next = !req.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
        end
    end

    for (genvar gi = 0; gi < PHYS_LANES; gi++)
    begin : g_lane
        localparam int PI = gi / 2;
        localparam int HI = gi % 2;
        if (gi < LANES)
        begin : g_on
            simd8_lane u_lane (
                .clk (clk),
                .ctl (ctl),
                .x   (a_pairs[PI][HI*LANE_W +: LANE_W]),
                .b   (b_pairs[PI][HI*LANE_W +: LANE_W]),
                .res (lane_res[gi])
            );
        end
        else
        begin : g_off
            assign lane_res[gi] = '0;
        end
    end

    simd8_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && emit),
        .from_reduce (req.cmd),
        .lanes       (lane_res),
        .rsp_ready   (rsp_ready),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp),
        .free        (free)
    );

    // An elementwise row answers in the next cycle, marked as such
    a_elem_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_ELEM)) |=> (rsp_valid && !rsp.from_reduce))
        else $error("elementwise row gave no result");

    // A reduce row without last_row never loads the output register
    a_reduce_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_REDUCE) && !req.last_row)
        |=> (rsp_valid == $past(rsp_valid && !rsp_ready)))
        else $error("intermediate reduce row produced a result");

    // The last reduce row closes the sequence and reports from_reduce
    a_reduce_close: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_REDUCE) && req.last_row)
        |=> (!running_reg && rsp_valid && rsp.from_reduce))
        else $error("reduction not closed on last row");

endmodule
